[hw/rtl/srtf_pkg.sv]
// Package for the SRTF scheduler: field widths, command codes, controller state type.
// No dependencies; compile first.
`default_nettype none

package srtf_pkg;

    localparam int TIME_W            = 16;  // time, arrival, burst and result widths
    localparam int SLOT_FIELD_W      = 4;   // slot fields on the channels
    localparam int PCOUNT_W          = 5;   // process_count register
    localparam int DEFAULT_MAX_PROCS = 16;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_CALC,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

[hw/rtl/srtf_in_if.sv]
// Command channel of the SRTF scheduler: valid/ready plus one command item.
// Depends on srtf_pkg.
`default_nettype none

interface srtf_in_if;
    import srtf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    command;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [TIME_W-1:0]       arrival_time;
    logic [TIME_W-1:0]       burst_time;

    modport source (output valid, output command, output slot, output arrival_time,
                    output burst_time, input ready);
    modport sink   (input valid, input command, input slot, input arrival_time,
                    input burst_time, output ready);
endinterface

`default_nettype wire

[hw/rtl/srtf_out_if.sv]
// Result channel of the SRTF scheduler: valid/ready plus one result item.
// Depends on srtf_pkg.
`default_nettype none

interface srtf_out_if;
    import srtf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [SLOT_FIELD_W-1:0] running_slot;
    logic                    cpu_idle;
    logic                    context_switch;
    logic                    process_finished;
    logic [TIME_W-1:0]       current_time;
    logic [TIME_W-1:0]       waiting_time;
    logic [TIME_W-1:0]       turnaround_time;
    logic                    all_done;

    modport source (output valid, output running_slot, output cpu_idle,
                    output context_switch, output process_finished, output current_time,
                    output waiting_time, output turnaround_time, output all_done,
                    input ready);
    modport sink   (input valid, input running_slot, input cpu_idle,
                    input context_switch, input process_finished, input current_time,
                    input waiting_time, input turnaround_time, input all_done,
                    output ready);
endinterface

`default_nettype wire

[hw/rtl/srtf_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/srtf_scheduler.sv]
// Top level of the SRTF scheduler: controller, finished marks, time and result register.
// Depends on srtf_pkg, srtf_in_if, srtf_out_if and srtf_ram.
`default_nettype none

// Preemptive shortest-remaining-time-first scheduler. A load command (command 0) writes
// the arrival time and burst of one process slot and restarts it; a burst of 0 is taken
// as 1, and a slot at or above MAX_PROCS is ignored. A tick command (command 1) picks,
// among slots 0 to process_count-1 that are unfinished and have arrived, the one with
// the least remaining burst (lowest slot on a tie), runs it for one unit and advances
// the saturating time. Every command gives exactly one result transfer. A completing
// slot reports waiting and turnaround time; waiting time never goes below zero.
// process_count 0 acts as 1, above MAX_PROCS as MAX_PROCS; write it only while idle.
// Sequence: a load goes from its transfer straight to the result load and back to ready;
// a tick goes through the scan, the write-back, the turnaround time and the result load.
// The slot store has one RAM read port that visits one slot per cycle in the scan. The
// result load waits while an earlier result is still held. The result register holds a
// result while the next command is already taken.
// Slot data lives in one RAM word per slot {arrival, burst, remaining}; finished marks
// are flip-flops cleared by reset. No clearing pass is needed after reset.
module srtf_scheduler #(
    parameter int MAX_PROCS = srtf_pkg::DEFAULT_MAX_PROCS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [srtf_pkg::PCOUNT_W-1:0] cfg_wdata,
    srtf_in_if.sink                            items,
    srtf_out_if.source                         results
);
    import srtf_pkg::*;

    localparam int SLOT_W = $clog2(MAX_PROCS);
    localparam int WORD_W = 3 * TIME_W;
    localparam int CW     = (PCOUNT_W > SLOT_W + 1) ? PCOUNT_W : SLOT_W + 1;
    localparam int SCW    = (SLOT_FIELD_W > SLOT_W + 1) ? SLOT_FIELD_W : SLOT_W + 1;
    localparam logic [SLOT_W:0] NO_SLOT = (SLOT_W + 1)'(MAX_PROCS);

    // control state
    state_t                state_reg, state_next;
    logic [PCOUNT_W-1:0]   cfg_count_reg, cfg_count_next;
    logic [TIME_W-1:0]     time_now_reg, time_now_next;
    logic [SLOT_W:0]       last_slot_reg, last_slot_next;
    logic [MAX_PROCS-1:0]  fin_mark_reg, fin_mark_next;
    logic [SLOT_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                  found_reg, found_next;
    logic                  is_tick_reg, is_tick_next;
    logic                  switch_reg, switch_next;
    logic                  finish_reg, finish_next;
    logic                  out_valid_reg, out_valid_next;

    // payload
    logic [SLOT_W-1:0]       best_idx_reg, best_idx_next;
    logic [TIME_W-1:0]       best_arr_reg, best_arr_next;
    logic [TIME_W-1:0]       best_bur_reg, best_bur_next;
    logic [TIME_W-1:0]       best_rem_reg, best_rem_next;
    logic [TIME_W-1:0]       turn_reg, turn_next;
    logic [SLOT_FIELD_W-1:0] out_slot_reg, out_slot_next;
    logic                    out_idle_reg, out_idle_next;
    logic                    out_switch_reg, out_switch_next;
    logic                    out_fin_reg, out_fin_next;
    logic [TIME_W-1:0]       out_time_reg, out_time_next;
    logic [TIME_W-1:0]       out_wait_reg, out_wait_next;
    logic [TIME_W-1:0]       out_turn_reg, out_turn_next;
    logic                    out_done_reg, out_done_next;

    // slot store port
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [SLOT_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic [TIME_W-1:0] rd_arr, rd_bur, rd_rem;

    logic [CW-1:0]        count_wide;
    logic [SLOT_W-1:0]    last_idx;
    logic [MAX_PROCS-1:0] done_mask;
    logic                 all_done_c;
    logic                 in_xfer;
    logic                 slot_ok;
    logic [SLOT_W-1:0]    slot_idx;
    logic [TIME_W-1:0]    load_bur;
    logic                 eligible, better;
    logic [TIME_W:0]      wait_diff;
    logic [TIME_W-1:0]    wait_c;
    logic                 tick_run;

    srtf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_PROCS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_arr = ram_rdata[3*TIME_W-1 -: TIME_W];
    assign rd_bur = ram_rdata[2*TIME_W-1 -: TIME_W];
    assign rd_rem = ram_rdata[TIME_W-1:0];

    // Clamp the slot count to 1..MAX_PROCS and keep the index of the last slot in use.
    assign count_wide = CW'(cfg_count_reg);
    always_comb
    begin
        priority if (count_wide == '0)
        begin
            last_idx = '0;
        end
        else if (count_wide > CW'(MAX_PROCS))
        begin
            last_idx = SLOT_W'(MAX_PROCS - 1);
        end
        else
        begin
            last_idx = SLOT_W'(count_wide - CW'(1));
        end
    end

    // A slot past the last one in use counts as done.
    always_comb
    begin
        for (int i = 0; i < MAX_PROCS; i++)
        begin
            done_mask[i] = fin_mark_reg[i] || (SLOT_W'(i) > last_idx);
        end
    end
    assign all_done_c = &done_mask;

    assign items.ready = (state_reg == ST_IDLE);
    assign in_xfer     = items.valid && items.ready;
    assign slot_ok     = SCW'(items.slot) < SCW'(MAX_PROCS);
    assign slot_idx    = SLOT_W'(items.slot);
    assign load_bur    = (items.burst_time == '0) ? TIME_W'(1) : items.burst_time;

    // Scan compare for the entry whose read data is on the RAM output.
    assign eligible = !fin_mark_reg[cmp_idx_reg] && (rd_arr <= time_now_reg);
    assign better   = eligible && (!found_reg || (rd_rem < best_rem_reg));

    // Waiting time clamps at zero.
    assign wait_diff = {1'b0, turn_reg} - {1'b0, best_bur_reg};
    assign wait_c    = wait_diff[TIME_W] ? '0 : wait_diff[TIME_W-1:0];
    assign tick_run  = is_tick_reg && found_reg;

    always_comb
    begin
        state_next      = state_reg;
        cfg_count_next  = cfg_count_reg;
        time_now_next   = time_now_reg;
        last_slot_next  = last_slot_reg;
        fin_mark_next   = fin_mark_reg;
        cmp_idx_next    = cmp_idx_reg;
        found_next      = found_reg;
        is_tick_next    = is_tick_reg;
        switch_next     = switch_reg;
        finish_next     = finish_reg;
        out_valid_next  = out_valid_reg;
        best_idx_next   = best_idx_reg;
        best_arr_next   = best_arr_reg;
        best_bur_next   = best_bur_reg;
        best_rem_next   = best_rem_reg;
        turn_next       = turn_reg;
        out_slot_next   = out_slot_reg;
        out_idle_next   = out_idle_reg;
        out_switch_next = out_switch_reg;
        out_fin_next    = out_fin_reg;
        out_time_next   = out_time_reg;
        out_wait_next   = out_wait_reg;
        out_turn_next   = out_turn_reg;
        out_done_next   = out_done_reg;
        ram_we          = 1'b0;
        ram_waddr       = best_idx_reg;
        ram_wdata       = {best_arr_reg, best_bur_reg, best_rem_reg};
        ram_raddr       = '0;

        if (cfg_we)
        begin
            cfg_count_next = cfg_wdata;
        end

        // Drop the result once the sink takes it.
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                // Read slot 0 now so the scan starts with data in the next cycle.
                ram_raddr = '0;
                if (in_xfer)
                begin
                    is_tick_next = (items.command == CMD_TICK);
                    if (items.command == CMD_TICK)
                    begin
                        cmp_idx_next = '0;
                        found_next   = 1'b0;
                        state_next   = ST_SCAN;
                    end
                    else
                    begin
                        if (slot_ok)
                        begin
                            ram_we                  = 1'b1;
                            ram_waddr               = slot_idx;
                            ram_wdata               = {items.arrival_time, load_bur, load_bur};
                            fin_mark_next[slot_idx] = 1'b0;
                        end
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_SCAN:
            begin
                ram_raddr = cmp_idx_reg + SLOT_W'(1);
                if (better)
                begin
                    found_next    = 1'b1;
                    best_idx_next = cmp_idx_reg;
                    best_arr_next = rd_arr;
                    best_bur_next = rd_bur;
                    best_rem_next = rd_rem;
                end
                if (cmp_idx_reg == last_idx)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    cmp_idx_next = cmp_idx_reg + SLOT_W'(1);
                end
            end

            ST_UPDATE:
            begin
                if (time_now_reg != '1)
                begin
                    time_now_next = time_now_reg + TIME_W'(1);
                end
                switch_next = 1'b0;
                finish_next = 1'b0;
                if (found_reg)
                begin
                    // Write back the chosen slot with one unit less to run.
                    switch_next    = ({1'b0, best_idx_reg} != last_slot_reg);
                    last_slot_next = {1'b0, best_idx_reg};
                    ram_we         = 1'b1;
                    ram_waddr      = best_idx_reg;
                    if (best_rem_reg <= TIME_W'(1))
                    begin
                        ram_wdata                   = {best_arr_reg, best_bur_reg, TIME_W'(0)};
                        fin_mark_next[best_idx_reg] = 1'b1;
                        finish_next                 = 1'b1;
                    end
                    else
                    begin
                        ram_wdata = {best_arr_reg, best_bur_reg,
                                     best_rem_reg - TIME_W'(1)};
                    end
                end
                state_next = ST_CALC;
            end

            ST_CALC:
            begin
                // Completion is the time after the tick.
                turn_next  = time_now_reg - best_arr_reg;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_slot_next   = tick_run ? SLOT_FIELD_W'(best_idx_reg) : '0;
                    out_idle_next   = is_tick_reg && !found_reg;
                    out_switch_next = tick_run && switch_reg;
                    out_fin_next    = tick_run && finish_reg;
                    out_time_next   = time_now_reg;
                    out_wait_next   = (tick_run && finish_reg) ? wait_c : '0;
                    out_turn_next   = (tick_run && finish_reg) ? turn_reg : '0;
                    out_done_next   = all_done_c;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_count_reg <= PCOUNT_W'(1);
            time_now_reg  <= '0;
            last_slot_reg <= NO_SLOT;
            fin_mark_reg  <= '0;
            cmp_idx_reg   <= '0;
            found_reg     <= 1'b0;
            is_tick_reg   <= 1'b0;
            switch_reg    <= 1'b0;
            finish_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cfg_count_reg <= cfg_count_next;
            time_now_reg  <= time_now_next;
            last_slot_reg <= last_slot_next;
            fin_mark_reg  <= fin_mark_next;
            cmp_idx_reg   <= cmp_idx_next;
            found_reg     <= found_next;
            is_tick_reg   <= is_tick_next;
            switch_reg    <= switch_next;
            finish_reg    <= finish_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg   <= best_idx_next;
        best_arr_reg   <= best_arr_next;
        best_bur_reg   <= best_bur_next;
        best_rem_reg   <= best_rem_next;
        turn_reg       <= turn_next;
        out_slot_reg   <= out_slot_next;
        out_idle_reg   <= out_idle_next;
        out_switch_reg <= out_switch_next;
        out_fin_reg    <= out_fin_next;
        out_time_reg   <= out_time_next;
        out_wait_reg   <= out_wait_next;
        out_turn_reg   <= out_turn_next;
        out_done_reg   <= out_done_next;
    end

    assign results.valid            = out_valid_reg;
    assign results.running_slot     = out_slot_reg;
    assign results.cpu_idle         = out_idle_reg;
    assign results.context_switch   = out_switch_reg;
    assign results.process_finished = out_fin_reg;
    assign results.current_time     = out_time_reg;
    assign results.waiting_time     = out_wait_reg;
    assign results.turnaround_time  = out_turn_reg;
    assign results.all_done         = out_done_reg;

    // A completing write-back marks the slot finished.
    a_finish_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE && found_reg && best_rem_reg <= TIME_W'(1))
        |=> fin_mark_reg[best_idx_reg])
        else $error("finished slot not marked");

    // Time never moves backward.
    a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        time_now_reg >= $past(time_now_reg))
        else $error("time went backward");

    // The scan stays within the slots in use.
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cmp_idx_reg <= last_idx))
        else $error("scan index past last slot in use");

    // An idle tick neither switches nor completes a slot.
    a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.cpu_idle)
        |-> (!results.process_finished && !results.context_switch))
        else $error("idle result with run flags");

    // Waiting time never exceeds turnaround time.
    a_wait_le_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.process_finished)
        |-> (results.turnaround_time >= results.waiting_time))
        else $error("waiting time above turnaround time");

endmodule

`default_nettype wire

[bench/tb_srtf_scheduler.sv]
// Self-checking testbench for srtf_scheduler: directed table, random phases, stall-free tail.
// Depends on srtf_pkg, srtf_in_if, srtf_out_if and the srtf_scheduler RTL.
`timescale 1ns / 100ps

module tb_srtf_scheduler;
    import srtf_pkg::*;

    localparam int NPROC        = DEFAULT_MAX_PROCS;
    localparam int NO_SLOT      = NPROC;       // last-run marker before any slot has run
    localparam int RAND_ITEMS   = 1100;        // random transfers before the tail
    localparam int LONG_HOLD    = 250;         // receiver hold-off that backs the block up
    localparam int DRAIN_CYCLES = 40;          // idle wait after the last owed result
    localparam int CYCLE_LIMIT  = 3_000_000;

    // One command transfer and one result transfer, at the widths of the channels.
    typedef struct packed {
        logic                    command;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [TIME_W-1:0]       arrival;
        logic [TIME_W-1:0]       burst;
    } cmd_item_t;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] run_slot;
        logic                    idle;
        logic                    cswitch;
        logic                    finished;
        logic [TIME_W-1:0]       now_t;
        logic [TIME_W-1:0]       wait_t;
        logic [TIME_W-1:0]       turn_t;
        logic                    all_fin;
    } report_t;

    // Directed table row: either a process_count write or a command, with an optional
    // hand-written expectation that replaces the predicted one.
    typedef struct {
        bit                  is_cfg;
        logic [PCOUNT_W-1:0] cfg_val;
        cmd_item_t           item;
        bit                  has_exp;
        report_t             exp;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [PCOUNT_W-1:0] cfg_wdata;

    srtf_in_if  cmd_ch ();
    srtf_out_if rpt_ch ();

    srtf_scheduler #(
        .MAX_PROCS (NPROC)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .items     (cmd_ch),
        .results   (rpt_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scheduler state as the testbench sees it; starts in the reset state.
    // ------------------------------------------------------------------
    logic [TIME_W-1:0]   arrival_mem [NPROC];
    logic [TIME_W-1:0]   burst_mem   [NPROC];
    logic [TIME_W-1:0]   remain_mem  [NPROC];
    bit                  done_mark   [NPROC];
    bit                  slot_written [NPROC];
    logic [TIME_W-1:0]   clock_now  = '0;
    logic [4:0]          last_run   = 5'(NO_SLOT);
    logic [PCOUNT_W-1:0] pcount_reg = PCOUNT_W'(1);

    report_t   sched_reports_q [$];   // results owed by the block, oldest first
    stim_row_t dir_rows [$];
    int        mismatch_count = 0;
    int        items_sent     = 0;
    int        cycle_count    = 0;
    bit        idle_on        = 1'b0; // random gaps and stalls allowed on both sides
    bit        sink_hold_req  = 1'b0; // ask the receiver for one long hold-off

    initial
    begin
        for (int i = 0; i < NPROC; i++)
        begin
            done_mark[i]    = 1'b0;
            slot_written[i] = 1'b0;
        end
    end

    // Out-of-range counts clamp: 0 acts as one slot, above NPROC as NPROC.
    function automatic int slots_active();
        if (pcount_reg == 0)
            return 1;
        if (pcount_reg > NPROC)
            return NPROC;
        return int'(pcount_reg);
    endfunction

    function automatic bit all_finished();
        int n;
        n = slots_active();
        for (int i = 0; i < n; i++)
            if (!done_mark[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Apply one accepted command to the state and return the result it must produce.
    task automatic schedule_next(input cmd_item_t it, output report_t rep_o);
        int                n;
        int                pick;
        logic [TIME_W-1:0] t_before;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] b;
        rep_o = '0;
        if (it.command == CMD_LOAD)
        begin
            // A zero burst is taken as one tick; a reload restarts the slot.
            b = (it.burst == '0) ? TIME_W'(1) : it.burst;
            arrival_mem[it.slot]  = it.arrival;
            burst_mem[it.slot]    = b;
            remain_mem[it.slot]   = b;
            done_mark[it.slot]    = 1'b0;
            slot_written[it.slot] = 1'b1;
        end
        else
        begin
            n        = slots_active();
            pick     = -1;
            t_before = clock_now;
            // Least remaining burst among arrived, unfinished slots; strict less keeps
            // the lowest slot on a tie.
            for (int i = 0; i < n; i++)
            begin
                if (!done_mark[i] && arrival_mem[i] <= t_before)
                    if (pick < 0 || remain_mem[i] < remain_mem[pick])
                        pick = i;
            end
            if (clock_now != '1)
                clock_now = clock_now + 1'b1;
            if (pick < 0)
            begin
                // Idle tick: keep the last run slot, no switch.
                rep_o.idle = 1'b1;
            end
            else
            begin
                rep_o.run_slot = pick[SLOT_FIELD_W-1:0];
                rep_o.cswitch  = (pick != int'(last_run));
                last_run       = pick[4:0];
                if (remain_mem[pick] <= 1)
                begin
                    remain_mem[pick] = '0;
                    done_mark[pick]  = 1'b1;
                    rep_o.finished   = 1'b1;
                    span             = clock_now - arrival_mem[pick];
                    rep_o.turn_t     = span;
                    // With the time stuck at its maximum the span can fall short of
                    // the burst; clamp the waiting time at zero.
                    rep_o.wait_t = (span > burst_mem[pick]) ? span - burst_mem[pick] : '0;
                end
                else
                begin
                    remain_mem[pick] = remain_mem[pick] - 1'b1;
                end
            end
        end
        rep_o.now_t   = clock_now;
        rep_o.all_fin = all_finished();
    endtask

    // ------------------------------------------------------------------
    // Item builders and the directed table
    // ------------------------------------------------------------------
    function automatic cmd_item_t load_item(input int s, input int a, input int b);
        cmd_item_t it;
        it.command = CMD_LOAD;
        it.slot    = s[SLOT_FIELD_W-1:0];
        it.arrival = a[TIME_W-1:0];
        it.burst   = b[TIME_W-1:0];
        return it;
    endfunction

    // Slot, arrival and burst mean nothing on a tick; fill them with noise.
    function automatic cmd_item_t tick_item();
        cmd_item_t it;
        it.command = CMD_TICK;
        it.slot    = SLOT_FIELD_W'($urandom_range(0, NPROC - 1));
        it.arrival = TIME_W'($urandom_range(0, 65535));
        it.burst   = TIME_W'($urandom_range(0, 65535));
        return it;
    endfunction

    // Mostly slots that arrive soon with short bursts, so phases run to completion;
    // now and then a full-range arrival or burst to reach every bit.
    function automatic cmd_item_t rand_load(input int s);
        int a;
        int b;
        if ($urandom_range(0, 15) == 0)
            a = $urandom_range(0, 65535);
        else
            a = int'(clock_now) + $urandom_range(0, 12);
        if ($urandom_range(0, 15) == 0)
            b = $urandom_range(0, 65535);
        else
            b = $urandom_range(0, 6);
        return load_item(s, a, b);
    endfunction

    function automatic report_t rep(input int s, input bit idl, input bit sw, input bit fin,
                                    input int now, input int wt, input int ta, input bit ad);
        report_t r;
        r.run_slot = s[SLOT_FIELD_W-1:0];
        r.idle     = idl;
        r.cswitch  = sw;
        r.finished = fin;
        r.now_t    = now[TIME_W-1:0];
        r.wait_t   = wt[TIME_W-1:0];
        r.turn_t   = ta[TIME_W-1:0];
        r.all_fin  = ad;
        return r;
    endfunction

    task automatic row_cfg(input logic [PCOUNT_W-1:0] v);
        stim_row_t r;
        r.is_cfg  = 1'b1;
        r.cfg_val = v;
        r.item    = '0;
        r.has_exp = 1'b0;
        r.exp     = '0;
        dir_rows.push_back(r);
    endtask

    task automatic row_chk(input cmd_item_t it, input bit has_exp, input report_t exp);
        stim_row_t r;
        r.is_cfg  = 1'b0;
        r.cfg_val = '0;
        r.item    = it;
        r.has_exp = has_exp;
        r.exp     = exp;
        dir_rows.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------
    // Offer one command, hold it until the transfer, then queue what it must produce.
    task automatic send_cmd(input cmd_item_t it, input bit has_exp, input report_t exp);
        report_t r;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= it.command;
        cmd_ch.slot         <= it.slot;
        cmd_ch.arrival_time <= it.arrival;
        cmd_ch.burst_time   <= it.burst;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        schedule_next(it, r);
        sched_reports_q.push_back(has_exp ? exp : r);
        items_sent++;
    endtask

    // Drop valid, wait for every owed result, then write process_count while idle.
    task automatic set_process_count(input logic [PCOUNT_W-1:0] v);
        cmd_ch.valid <= 1'b0;
        while (sched_reports_q.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        pcount_reg  = v;
    endtask

    // ------------------------------------------------------------------
    // Result side: stall in bursts, honor the long hold-off, check each transfer.
    // ------------------------------------------------------------------
    function automatic void compare_field(input string name, input logic [TIME_W-1:0] want,
                                          input logic [TIME_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic check_report();
        report_t got;
        report_t want;
        got.run_slot = rpt_ch.running_slot;
        got.idle     = rpt_ch.cpu_idle;
        got.cswitch  = rpt_ch.context_switch;
        got.finished = rpt_ch.process_finished;
        got.now_t    = rpt_ch.current_time;
        got.wait_t   = rpt_ch.waiting_time;
        got.turn_t   = rpt_ch.turnaround_time;
        got.all_fin  = rpt_ch.all_done;
        if (sched_reports_q.size() == 0)
        begin
            $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
            mismatch_count++;
        end
        else
        begin
            want = sched_reports_q.pop_front();
            compare_field("running_slot", TIME_W'(want.run_slot), TIME_W'(got.run_slot));
            compare_field("cpu_idle", TIME_W'(want.idle), TIME_W'(got.idle));
            compare_field("context_switch", TIME_W'(want.cswitch), TIME_W'(got.cswitch));
            compare_field("process_finished", TIME_W'(want.finished), TIME_W'(got.finished));
            compare_field("current_time", want.now_t, got.now_t);
            compare_field("waiting_time", want.wait_t, got.wait_t);
            compare_field("turnaround_time", want.turn_t, got.turn_t);
            compare_field("all_done", TIME_W'(want.all_fin), TIME_W'(got.all_fin));
        end
    endtask

    initial
    begin : result_side
        rpt_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rpt_ch.valid === 1'b1 && rpt_ch.ready === 1'b1)
                check_report();
            if (sink_hold_req)
            begin
                // Hold off long enough for the result register and the command side to
                // back up while the sender keeps offering.
                sink_hold_req = 1'b0;
                rpt_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                rpt_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            rpt_ch.ready <= 1'b1;
        end
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, directed table, random phases, stall-free tail, verdict.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int phase;
        int rand_start;
        int n;
        int ticks;
        int pcv;

        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.command      <= CMD_LOAD;
        cmd_ch.slot         <= '0;
        cmd_ch.arrival_time <= '0;
        cmd_ch.burst_time   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Hand-written expectations stand on the rows whose result is
        // plain from the rules; the rest go through the predictor.
        // Right after reset: load result is all zero, first run counts as a switch.
        row_chk(load_item(0, 0, 3), 1'b1, rep(0, 0, 0, 0, 0, 0, 0, 0));
        row_chk(tick_item(), 1'b1, rep(0, 0, 1, 0, 1, 0, 0, 0));
        row_chk(tick_item(), 1'b0, '0);
        row_chk(tick_item(), 1'b1, rep(0, 0, 0, 1, 3, 0, 3, 1));
        // Everything done: idle tick, time moves, no switch.
        row_chk(tick_item(), 1'b1, rep(0, 1, 0, 0, 4, 0, 0, 1));
        // process_count 0 acts as 1; zero burst runs as one tick.
        row_cfg(5'd0);
        row_chk(load_item(0, 0, 0), 1'b1, rep(0, 0, 0, 0, 4, 0, 0, 0));
        row_chk(tick_item(), 1'b1, rep(0, 0, 0, 1, 5, 4, 5, 1));
        // Three slots: one never arrives (extremes), a tie goes to the lower slot.
        row_cfg(5'd3);
        row_chk(load_item(1, 65535, 65535), 1'b0, '0);
        row_chk(load_item(2, 5, 2), 1'b0, '0);
        row_chk(load_item(0, 0, 2), 1'b0, '0);
        repeat (5) row_chk(tick_item(), 1'b0, '0);
        // Preemption: a shorter job arriving mid-run takes over, then hands back.
        row_chk(load_item(2, 10, 5), 1'b0, '0);
        row_chk(tick_item(), 1'b0, '0);
        row_chk(load_item(0, 11, 1), 1'b0, '0);
        repeat (2) row_chk(tick_item(), 1'b0, '0);
        // Reload a running slot: longest burst, then latest arrival.
        row_cfg(5'd1);
        row_chk(load_item(0, 0, 65535), 1'b0, '0);
        row_chk(tick_item(), 1'b0, '0);
        row_chk(load_item(0, 65535, 1), 1'b0, '0);
        row_chk(tick_item(), 1'b0, '0);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                set_process_count(dir_rows[i].cfg_val);
            else
                send_cmd(dir_rows[i].item, dir_rows[i].has_exp, dir_rows[i].exp);
        end

        // Random phases: write a count, load every slot in use, then tick until all
        // are done (or a cap), with the odd mid-run reload and trailing idle ticks.
        phase      = 0;
        rand_start = items_sent;
        while (items_sent - rand_start < RAND_ITEMS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            case (phase)
                0: pcv = 31;
                1: pcv = NPROC;
                2: pcv = 0;
                default:
                begin
                    if ($urandom_range(0, 7) == 0)
                        pcv = $urandom_range(0, 31);
                    else
                        pcv = $urandom_range(1, 6);
                end
            endcase
            set_process_count(pcv[PCOUNT_W-1:0]);
            n = slots_active();
            for (int s = 0; s < n; s++)
                send_cmd(rand_load(s), 1'b0, '0);
            // Noise load, often to a slot outside the ones in use.
            if ($urandom_range(0, 2) == 0)
                send_cmd(rand_load($urandom_range(0, NPROC - 1)), 1'b0, '0);
            if (phase == 3)
                sink_hold_req = 1'b1;
            ticks = 0;
            while (!all_finished() && ticks < 3 * n + 12)
            begin
                if ($urandom_range(0, 11) == 0)
                    send_cmd(rand_load($urandom_range(0, n - 1)), 1'b0, '0);
                send_cmd(tick_item(), 1'b0, '0);
                ticks++;
            end
            repeat ($urandom_range(0, 2)) send_cmd(tick_item(), 1'b0, '0);
            phase++;
        end

        // Tail with no gaps or stalls: one long job run to completion, then a job that
        // arrives at the latest possible time and leaves the ticks idle.
        idle_on = 1'b0;
        set_process_count(5'd1);
        send_cmd(load_item(0, int'(clock_now), 40), 1'b0, '0);
        repeat (41) send_cmd(tick_item(), 1'b0, '0);
        send_cmd(load_item(0, 65535, 2), 1'b0, '0);
        repeat (3) send_cmd(tick_item(), 1'b0, '0);

        // Drain: wait for every owed result, then give the block time to misbehave.
        cmd_ch.valid <= 1'b0;
        while (sched_reports_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && sched_reports_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/srtf_pkg.sv
hw/rtl/srtf_in_if.sv
hw/rtl/srtf_out_if.sv
hw/rtl/srtf_ram.sv
hw/rtl/srtf_scheduler.sv
bench/tb_srtf_scheduler.sv
